>>> rtl/assert_macros.svh
// Assertion macros used by the deframer RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define WDF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define WDF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define WDF_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define WDF_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/wdf_pkg.sv
// Types and constants of the frame deframer.
`timescale 1ns / 1ps

package wdf_pkg;

  typedef enum logic [6:0] {
    PH_HDR0  = 7'b0000001,
    PH_HDR1  = 7'b0000010,
    PH_EXT16 = 7'b0000100,
    PH_EXT64 = 7'b0001000,
    PH_KEY   = 7'b0010000,
    PH_PAY   = 7'b0100000,
    PH_SKIP  = 7'b1000000
  } phase_e;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

>>> rtl/websocket_frame_deframer.sv
// Frame deframer: header parse, length decode, mask key capture, payload unmask.
//
//   channel  handshake               payload
//   in       in_valid_i / in_stall_o   in_byte_i, end_of_buffer_i
//   out      out_valid_o / out_stall_i out_byte_o, byte_valid_o, frame_done_o,
//                                     status_o, payload_length_o,
//                                     frame_opcode_o, fin_flag_o, mask_flag_o
//
// One byte per clock while in_stall_o is low; a payload byte or end-of-buffer byte
// leaves a result in the output register in the cycle after acceptance.
// Reset clears the parse state and empties the output register.
// in_stall_o is high only while a held result is stalled by out_stall_i.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module websocket_frame_deframer #(
  parameter int LEN_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        frame_done_o,
  output logic [1:0]  status_o,
  output logic [31:0] payload_length_o,
  output logic [3:0]  frame_opcode_o,
  output logic        fin_flag_o,
  output logic        mask_flag_o
);

  wdf_pkg::phase_e       phase_q, phase_d;
  logic [3:0]            hidx_q, hidx_d;
  logic [LEN_BITS-1:0]   accum_q, accum_d;
  logic                  ovf_q, ovf_d;
  logic [31:0]           key_q, key_d;
  logic                  mask_on_q, mask_on_d;
  logic [LEN_BITS-1:0]   left_q, left_d;
  logic [1:0]            kpos_q, kpos_d;
  logic                  too_large_q, too_large_d;
  logic [3:0]            opc_q, opc_d;
  logic                  fin_q, fin_d;

  logic                  accept;
  logic                  load;
  logic                  complete;
  logic                  start;
  logic                  bvalid;
  logic [7:0]            obyte;
  logic [7:0]            key_byte;
  logic [1:0]            status;
  logic [63:0]           len_wide;
  logic                  out_valid_q, out_valid_d;

  logic [7:0]            out_byte_q;
  logic                  byte_valid_q;
  logic                  frame_done_q;
  logic [1:0]            status_q;
  logic [31:0]           payload_length_q;
  logic [3:0]            frame_opcode_q;
  logic                  fin_flag_q;
  logic                  mask_flag_q;
  logic                  summary_clear;
  logic                  restarted;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    case (kpos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    hidx_d      = hidx_q;
    accum_d     = accum_q;
    ovf_d       = ovf_q;
    key_d       = key_q;
    mask_on_d   = mask_on_q;
    left_d      = left_q;
    kpos_d      = kpos_q;
    too_large_d = too_large_q;
    opc_d       = opc_q;
    fin_d       = fin_q;
    complete    = 1'b0;
    start       = 1'b0;
    bvalid      = 1'b0;
    obyte       = 8'd0;

    case (phase_q)
      wdf_pkg::PH_HDR0: begin
        fin_d   = in_byte_i[7];
        opc_d   = in_byte_i[3:0];
        phase_d = wdf_pkg::PH_HDR1;
      end
      wdf_pkg::PH_HDR1: begin
        mask_on_d = in_byte_i[7];
        hidx_d    = 4'd0;
        accum_d   = '0;
        ovf_d     = 1'b0;
        if (in_byte_i[6:0] == wdf_pkg::LEN_CODE_EXT16) begin
          phase_d = wdf_pkg::PH_EXT16;
        end else if (in_byte_i[6:0] == wdf_pkg::LEN_CODE_EXT64) begin
          phase_d = wdf_pkg::PH_EXT64;
        end else begin
          accum_d  = LEN_BITS'(in_byte_i[6:0]);
          complete = 1'b1;
        end
      end
      wdf_pkg::PH_EXT16, wdf_pkg::PH_EXT64: begin
        accum_d = {accum_q[LEN_BITS-9:0], in_byte_i};
        ovf_d   = ovf_q | (|accum_q[LEN_BITS-1 -: 8]);
        hidx_d  = hidx_q + 4'd1;
        if (hidx_d == ((phase_q == wdf_pkg::PH_EXT16) ? wdf_pkg::EXT16_BYTES
                                                       : wdf_pkg::EXT64_BYTES)) begin
          complete = 1'b1;
        end
      end
      wdf_pkg::PH_KEY: begin
        key_d  = {key_q[23:0], in_byte_i};
        hidx_d = hidx_q + 4'd1;
        if (hidx_d == wdf_pkg::KEY_BYTES) begin
          start = 1'b1;
        end
      end
      wdf_pkg::PH_PAY: begin
        obyte  = in_byte_i ^ (mask_on_q ? key_byte : 8'd0);
        kpos_d = kpos_q + 2'd1;
        bvalid = 1'b1;
        left_d = left_q - LEN_BITS'(1);
        if (left_q == LEN_BITS'(1)) begin
          phase_d = wdf_pkg::PH_SKIP;
        end
      end
      default: begin
      end
    endcase

    if (complete) begin
      if (ovf_d) begin
        too_large_d = 1'b1;
        phase_d     = wdf_pkg::PH_SKIP;
      end else if (mask_on_d) begin
        hidx_d  = 4'd0;
        phase_d = wdf_pkg::PH_KEY;
      end else begin
        start = 1'b1;
      end
    end

    if (start) begin
      left_d  = accum_d;
      kpos_d  = 2'd0;
      phase_d = (accum_d != '0) ? wdf_pkg::PH_PAY : wdf_pkg::PH_SKIP;
    end

    if (too_large_d) begin
      status = wdf_pkg::ST_TOO_LARGE;
    end else if (phase_d == wdf_pkg::PH_SKIP) begin
      status = wdf_pkg::ST_OK;
    end else begin
      status = wdf_pkg::ST_TRUNCATED;
    end
  end

  assign len_wide    = 64'(accum_d);
  assign load        = accept & (bvalid | end_of_buffer_i);
  assign out_valid_d = load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wdf_pkg::PH_HDR0;
      hidx_q      <= 4'd0;
      accum_q     <= '0;
      ovf_q       <= 1'b0;
      key_q       <= 32'd0;
      mask_on_q   <= 1'b0;
      left_q      <= '0;
      kpos_q      <= 2'd0;
      too_large_q <= 1'b0;
      opc_q       <= 4'd0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        if (end_of_buffer_i) begin
          phase_q     <= wdf_pkg::PH_HDR0;
          hidx_q      <= 4'd0;
          accum_q     <= '0;
          ovf_q       <= 1'b0;
          key_q       <= 32'd0;
          mask_on_q   <= 1'b0;
          left_q      <= '0;
          kpos_q      <= 2'd0;
          too_large_q <= 1'b0;
          opc_q       <= 4'd0;
          fin_q       <= 1'b0;
        end else begin
          phase_q     <= phase_d;
          hidx_q      <= hidx_d;
          accum_q     <= accum_d;
          ovf_q       <= ovf_d;
          key_q       <= key_d;
          mask_on_q   <= mask_on_d;
          left_q      <= left_d;
          kpos_q      <= kpos_d;
          too_large_q <= too_large_d;
          opc_q       <= opc_d;
          fin_q       <= fin_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q     <= obyte;
      byte_valid_q   <= bvalid;
      frame_done_q   <= end_of_buffer_i;
      if (end_of_buffer_i) begin
        status_q         <= status;
        payload_length_q <= len_wide[31:0];
        frame_opcode_q   <= opc_d;
        fin_flag_q       <= fin_d;
        mask_flag_q      <= mask_on_d;
      end else begin
        status_q         <= wdf_pkg::ST_OK;
        payload_length_q <= 32'd0;
        frame_opcode_q   <= 4'd0;
        fin_flag_q       <= 1'b0;
        mask_flag_q      <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign byte_valid_o     = byte_valid_q;
  assign frame_done_o     = frame_done_q;
  assign status_o         = status_q;
  assign payload_length_o = payload_length_q;
  assign frame_opcode_o   = frame_opcode_q;
  assign fin_flag_o       = fin_flag_q;
  assign mask_flag_o      = mask_flag_q;

  assign summary_clear = (status_q == wdf_pkg::ST_OK) & (payload_length_q == 32'd0);
  assign restarted     = (phase_q == wdf_pkg::PH_HDR0) & out_valid_q & frame_done_q;

  `WDF_ASSERT_IMP(a_no_empty_result, clk_i, rst_ni, out_valid_o, byte_valid_o || frame_done_o)
  `WDF_ASSERT_IMP(a_pay_has_bytes, clk_i, rst_ni, phase_q == wdf_pkg::PH_PAY, left_q != '0)
  `WDF_ASSERT_IMP(a_summary_only_at_end, clk_i, rst_ni, out_valid_o && !frame_done_o, summary_clear)
  `WDF_ASSERT_NXT(a_restart_after_end, clk_i, rst_ni, accept && end_of_buffer_i, restarted)

endmodule
